// ===== design/arw_pkg.sv =====
// Package for the anti-replay window: operation codes, field widths
// and the reset value of the reject limit. No dependencies.
package arw_pkg;

	// field widths
	localparam int CNT_W    = 64;
	localparam int OP_W     = 2;
	localparam int WORD_W   = 64;
	localparam int WORD_LOG = 6;

	// operation codes carried on op
	localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
	localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// reject limit after reset
	localparam logic [CNT_W-1:0] REJECT_LIMIT_RST = 64'hFFFF_FFFF_FFFF_DFFF;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

endpackage

// ===== design/arw_sub_unit.sv =====
// Shared 64-bit subtractor with borrow out, used for every counter
// compare of the window. Depends on arw_pkg.
module arw_sub_unit (
	input  arw_pkg::cnt_t a,
	input  arw_pkg::cnt_t b,
	output arw_pkg::cnt_t diff,
	output logic          borrow
);
	import arw_pkg::*;

	logic [CNT_W:0] full;

	// a - b with the borrow in the top bit
	assign full   = {1'b0, a} - {1'b0, b};
	assign diff   = full[CNT_W-1:0];
	assign borrow = full[CNT_W];

endmodule

// ===== design/arw_mark_ram.sv =====
// Slot bitmap storage: one write port and one read port with registered
// read data, one 64-bit word per entry. Depends on arw_pkg.
module arw_mark_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  arw_pkg::word_t wdata,
	input  logic [AW-1:0] raddr,
	output arw_pkg::word_t rdata
);
	import arw_pkg::*;

	word_t mem [0:DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/anti_replay_window.sv =====
// Anti-replay window over a ring bitmap of WINDOW_BITS slots (a power of two,
// 64 to 65536), held as WINDOW_BITS/64 words in a single-port-write RAM.
// Depends on arw_pkg, arw_sub_unit and arw_mark_ram.
//
// An item is taken when start is high and busy is low. It passes the states
// CMP0, CMP1, CMP2 and CHK; its verdict, registered in CHK, appears on
// acceptable, marked by done, for one cycle; the receiver cannot stall it, so
// it must take every done beat. All 64-bit compares run one per cycle through
// a single shared subtractor, and the bitmap is touched one word per
// read-modify-write. A check ends after CHK; a record then marks its slot
// (MARK_RD, MARK_WR), first clearing each word the window slides over when it
// moves forward by less than WINDOW_BITS (SL_RD, SL_WR per word, at most
// WINDOW_BITS/64 + 1 words), or sweeping all WINDOW_BITS/64 words on the first
// record after reset or clear and on a jump of WINDOW_BITS or more. A clear
// item sweeps all words. Busy stays high until the item is through, and after
// reset while the block sweeps the bitmap. The user must write the reject
// limit through cfg_valid/cfg_data only while no item is in flight; the block
// does not enforce this. cfg_ready is always high.
module anti_replay_window #(
	parameter int WINDOW_BITS = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [arw_pkg::OP_W-1:0]      op,
	input  arw_pkg::cnt_t                 counter,
	output logic                          done,
	output logic                          acceptable,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  arw_pkg::cnt_t                 cfg_data
);
	import arw_pkg::*;

	localparam int LOGW = $clog2(WINDOW_BITS);
	localparam int NW   = WINDOW_BITS / WORD_W;
	localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
	localparam int NB   = LOGW + 1;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CMP0    = 4'd1;
	localparam logic [3:0] S_CMP1    = 4'd2;
	localparam logic [3:0] S_CMP2    = 4'd3;
	localparam logic [3:0] S_CHK     = 4'd4;
	localparam logic [3:0] S_SL_RD   = 4'd5;
	localparam logic [3:0] S_SL_WR   = 4'd6;
	localparam logic [3:0] S_MARK_RD = 4'd7;
	localparam logic [3:0] S_MARK_WR = 4'd8;
	localparam logic [3:0] S_SWEEP   = 4'd9;

	function automatic logic [AW-1:0] word_of(input logic [LOGW-1:0] s);
		return AW'(s >> WORD_LOG);
	endfunction

	logic [3:0]      state_q, state_d;
	logic [3:0]      sweep_ret_q;
	logic [AW-1:0]   swp_q;
	cnt_t            limit_q;
	cnt_t            high_q;
	logic            any_q;
	logic [OP_W-1:0] op_q;
	cnt_t            cnt_q;
	logic            lt_lim_q, gt_q, adv_big_q, far_q;
	logic [LOGW-1:0] adv_lo_q;
	logic [LOGW-1:0] cur_q;
	logic [LOGW-1:0] rem_q;
	logic            done_q, acc_q;

	cnt_t            sub_a, sub_b, sub_diff;
	logic            sub_borrow;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	word_t           wdata, rdata;
	logic [LOGW-1:0] cnt_slot;
	logic            slot_bit, ok;
	logic [NB-1:0]   room, rem_ext, chunk;
	word_t           clr_mask;
	logic            slide_last;

	assign cnt_slot  = cnt_q[LOGW-1:0];
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign acceptable = acc_q;

	// shared subtractor, operands picked by the sequencer
	always_comb begin
		sub_a = cnt_q;
		sub_b = high_q;
		unique case (state_q)
			S_CMP0: sub_b = limit_q;
			S_CMP2: begin
				sub_a = high_q;
				sub_b = cnt_q;
			end
			default: ;
		endcase
	end

	arw_sub_unit u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	// slide chunk: bits from cur_q up to the end of its word or the end of the run
	assign room       = NB'(WORD_W) - NB'(cur_q[WORD_LOG-1:0]);
	assign rem_ext    = NB'(rem_q);
	assign chunk      = (rem_ext < room) ? rem_ext : room;
	assign clr_mask   = (~({WORD_W{1'b1}} << chunk)) << cur_q[WORD_LOG-1:0];
	assign slide_last = (rem_ext == chunk);

	// verdict from the compare flags and the slot bit
	assign slot_bit = rdata[cnt_q[WORD_LOG-1:0]];
	assign ok = ((op_q == OP_CHECK) || (op_q == OP_RECORD)) && lt_lim_q &&
		(!any_q || gt_q || (!far_q && !slot_bit));

	// bitmap port selection
	always_comb begin
		we    = 1'b0;
		waddr = word_of(cnt_slot);
		wdata = '0;
		raddr = (state_q == S_SL_RD) ? word_of(cur_q) : word_of(cnt_slot);
		unique case (state_q)
			S_SWEEP: begin
				we    = 1'b1;
				waddr = swp_q;
			end
			S_SL_WR: begin
				we    = 1'b1;
				waddr = word_of(cur_q);
				wdata = rdata & ~clr_mask;
			end
			S_MARK_WR: begin
				we    = 1'b1;
				wdata = rdata | (word_t'(1) << cnt_q[WORD_LOG-1:0]);
			end
			default: ;
		endcase
	end

	arw_mark_ram #(
		.DEPTH (NW),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (start) state_d = S_CMP0;
			S_CMP0:    state_d = S_CMP1;
			S_CMP1:    state_d = S_CMP2;
			S_CMP2:    state_d = S_CHK;
			S_CHK: begin
				case (op_q)
					OP_CLEAR: state_d = S_SWEEP;
					OP_RECORD: begin
						if (!any_q || (gt_q && adv_big_q)) state_d = S_SWEEP;
						else if (gt_q) state_d = S_SL_RD;
						else state_d = S_MARK_RD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SL_RD:   state_d = S_SL_WR;
			S_SL_WR:   state_d = slide_last ? S_MARK_RD : S_SL_RD;
			S_MARK_RD: state_d = S_MARK_WR;
			S_MARK_WR: state_d = S_IDLE;
			S_SWEEP:   if (swp_q == AW'(NW - 1)) state_d = sweep_ret_q;
			default:   state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_ret_q <= S_IDLE;
			swp_q       <= '0;
			limit_q     <= REJECT_LIMIT_RST;
			high_q      <= '0;
			any_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_CHK);
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (state_q == S_SWEEP) begin
				swp_q <= (swp_q == AW'(NW - 1)) ? '0 : swp_q + AW'(1);
			end
			if (state_q == S_CHK) begin
				case (op_q)
					OP_CLEAR: begin
						high_q      <= '0;
						any_q       <= 1'b0;
						sweep_ret_q <= S_IDLE;
					end
					OP_RECORD: begin
						sweep_ret_q <= S_MARK_RD;
						if (!any_q || gt_q) begin
							high_q <= cnt_q;
						end
						any_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// item payload, compare flags and slide pointers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= op;
			cnt_q <= counter;
		end
		unique case (state_q)
			S_CMP0: lt_lim_q <= sub_borrow;
			S_CMP1: begin
				gt_q      <= !sub_borrow && (|sub_diff);
				adv_big_q <= |sub_diff[CNT_W-1:LOGW];
				adv_lo_q  <= sub_diff[LOGW-1:0];
			end
			S_CMP2: far_q <= |sub_diff[CNT_W-1:LOGW];
			S_CHK: begin
				acc_q <= ok;
				cur_q <= high_q[LOGW-1:0] + LOGW'(1);
				rem_q <= adv_lo_q;
			end
			S_SL_WR: begin
				cur_q <= cur_q + LOGW'(chunk);
				rem_q <= rem_q - LOGW'(chunk);
			end
			default: ;
		endcase
	end

	// the strobe only follows a verdict cycle
	a_done_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_CHK))
		else $error("done without a verdict cycle");

	// results never come on consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	// a slide never runs out of slots to clear
	a_slide_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SL_RD) |-> (rem_q != '0))
		else $error("slide with nothing left to clear");

	// marking a slot only happens once the window holds a record
	a_mark_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_WR) |-> any_q)
		else $error("slot marked before any record");

endmodule

// ===== test/arw_verdict_checker.sv =====
// Verdict checker for anti_replay_window: keeps its own ring bitmap window,
// predicts the acceptable bit of every start beat and compares each done beat.
// Depends on arw_pkg.
module arw_verdict_checker #(
	parameter int WINDOW_BITS = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [arw_pkg::OP_W-1:0] op,
	input  arw_pkg::cnt_t            counter,
	input  logic                     done,
	input  logic                     acceptable,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  arw_pkg::cnt_t            cfg_data,
	output int unsigned              mismatches,
	output int unsigned              awaiting
);
	import arw_pkg::*;

	localparam cnt_t WIN = cnt_t'(WINDOW_BITS);

	typedef struct {
		logic [OP_W-1:0] op;
		cnt_t            counter;
		logic            verdict;
	} verdict_t;

	verdict_t expected_verdicts[$];

	// model of the window
	logic [WINDOW_BITS-1:0] slot_marks;
	cnt_t                   top_seen;
	logic                   seen_any;
	cnt_t                   limit;
	int unsigned            bad;

	// check verdict, taken before any update
	function automatic logic window_admits(input cnt_t c);
		if (c >= limit)
			return 1'b0;
		if (!seen_any)
			return 1'b1;
		if (c > top_seen)
			return 1'b1;
		if (top_seen - c >= WIN)
			return 1'b0;
		return !slot_marks[c % WIN];
	endfunction

	// record: slide the window forward if new highest, then mark the slot
	task automatic mark_counter(input cnt_t c);
		cnt_t k;
		if (!seen_any) begin
			seen_any   = 1'b1;
			slot_marks = '0;
			top_seen   = c;
		end else if (c > top_seen) begin
			if (c - top_seen >= WIN) begin
				slot_marks = '0;
			end else begin
				// slot of c itself is set below, so stop one short
				for (k = top_seen + 1; k < c; k++)
					slot_marks[k % WIN] = 1'b0;
			end
			top_seen = c;
		end
		slot_marks[c % WIN] = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t ev;
		if (!arst_n) begin
			expected_verdicts.delete();
			slot_marks = '0;
			top_seen   = '0;
			seen_any   = 1'b0;
			limit      = REJECT_LIMIT_RST;
			bad        = 0;
			mismatches <= 0;
			awaiting   <= 0;
		end else begin
			// result beat: compare with the oldest expectation
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					bad++;
					$display("%0t: unexpected result beat: expected none, actual acceptable=%0b",
						$time, acceptable);
				end else begin
					ev = expected_verdicts.pop_front();
					if (acceptable !== ev.verdict) begin
						bad++;
						$display("%0t: acceptable for op %0d counter %h: expected %0b, actual %0b",
							$time, ev.op, ev.counter, ev.verdict, acceptable);
					end
				end
			end

			if (cfg_valid && cfg_ready)
				limit = cfg_data;

			// item beat: predict and update the model
			if (start && !busy) begin
				ev.op      = op;
				ev.counter = counter;
				case (op)
					OP_CHECK: begin
						ev.verdict = window_admits(counter);
					end
					OP_RECORD: begin
						ev.verdict = window_admits(counter);
						mark_counter(counter);
					end
					OP_CLEAR: begin
						ev.verdict = 1'b0;
						slot_marks = '0;
						top_seen   = '0;
						seen_any   = 1'b0;
					end
					default: begin
						ev.verdict = 1'b0;
					end
				endcase
				expected_verdicts.push_back(ev);
			end

			mismatches <= bad;
			awaiting   <= expected_verdicts.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for anti_replay_window: drives check, record and clear beats
// and reject-limit writes over several phases; arw_verdict_checker does the checking.
// Depends on arw_pkg, anti_replay_window and arw_verdict_checker.
module tb;
	import arw_pkg::*;

	localparam int              WIN         = 2048;
	localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
	localparam int              STALL_LIMIT = 4000;
	localparam int              PHASES      = 6;
	localparam int              PHASE_ITEMS = 240;
	localparam cnt_t            CNT_MAX     = '1;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [OP_W-1:0] op;
	cnt_t            counter;
	logic            done;
	logic            acceptable;
	logic            cfg_valid;
	logic            cfg_ready;
	cnt_t            cfg_data;

	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned quiet_cycles = 0;
	int unsigned idle_pct     = 0;
	cnt_t        cursor       = '0;	// highest counter recorded so far, roughly

	anti_replay_window #(
		.WINDOW_BITS(WIN)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.counter   (counter),
		.done      (done),
		.acceptable(acceptable),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	arw_verdict_checker #(
		.WINDOW_BITS(WIN)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.counter   (counter),
		.done      (done),
		.acceptable(acceptable),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.awaiting  (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles in which no beat of any kind is taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic cnt_t rand64();
		return {$urandom, $urandom};
	endfunction

	// saturating steps around the cursor
	function automatic cnt_t cnt_below(input cnt_t base, input cnt_t amount);
		return (amount > base) ? '0 : base - amount;
	endfunction

	function automatic cnt_t cnt_above(input cnt_t base, input cnt_t amount);
		return (base > CNT_MAX - amount) ? CNT_MAX : base + amount;
	endfunction

	// one item beat; start stays high afterwards
	task automatic send(input logic [OP_W-1:0] o, input cnt_t c);
		start   <= 1'b1;
		op      <= o;
		counter <= c;
		do @(posedge clk); while (busy);
		if (o == OP_RECORD && c > cursor)
			cursor = c;
	endtask

	task automatic pause();
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every verdict has come back
	task automatic wait_drained();
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input cnt_t v);
		wait_drained();
		while (busy)
			@(posedge clk);
		// let any trailing sweep finish
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int unsigned pick;
		cnt_t        gap;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			// clear, then restart the stream somewhere else
			send(OP_CLEAR, rand64());
			case ($urandom_range(0, 3))
				0:       cursor = cnt_t'($urandom_range(0, 5000));
				1:       cursor = {32'h0, $urandom};
				2:       cursor = CNT_MAX - cnt_t'($urandom_range(0, 20000));
				default: cursor = rand64();
			endcase
		end else if (pick < 3) begin
			send(OP_SPARE, rand64());
		end else if (pick < 6) begin
			send((pick == 5) ? OP_RECORD : OP_CHECK, rand64());
		end else if (pick < 46) begin
			// in-order arrival moving the window forward
			case ($urandom_range(0, 49))
				0:             gap = cnt_t'(WIN) + cnt_t'($urandom_range(0, 100000));
				1:             gap = cnt_t'(WIN);
				2, 3, 4, 5, 6: gap = cnt_t'($urandom_range(200, WIN - 1));
				7, 8, 9, 10, 11, 12, 13, 14:
				               gap = cnt_t'($urandom_range(9, 200));
				default:       gap = cnt_t'($urandom_range(1, 8));
			endcase
			send(OP_RECORD, cnt_above(cursor, gap));
		end else if (pick < 71) begin
			send(OP_CHECK, cnt_below(cursor, cnt_t'($urandom_range(0, WIN + 50))));
		end else if (pick < 86) begin
			// late arrival inside or just outside the window
			send(OP_RECORD, cnt_below(cursor, cnt_t'($urandom_range(0, WIN + 50))));
		end else if (pick < 96) begin
			send(OP_CHECK, cnt_above(cursor, cnt_t'($urandom_range(1, 3000))));
		end else if (pick < 98) begin
			// window edge
			send($urandom_range(0, 1) ? OP_RECORD : OP_CHECK,
				cnt_below(cursor, cnt_t'(WIN - 1) + cnt_t'($urandom_range(0, 2))));
		end else begin
			send($urandom_range(0, 1) ? OP_RECORD : OP_CHECK,
				cnt_below(cursor, cnt_t'(WIN) + cnt_t'($urandom_range(0, 1 << 20))));
		end
	endtask

	initial begin
		int unsigned ph;
		int unsigned n;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		op        <= OP_CHECK;
		counter   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: before the first record and the reject limit edges
		send(OP_CHECK, '0);
		send(OP_CHECK, CNT_MAX);
		send(OP_CHECK, REJECT_LIMIT_RST - 1);
		send(OP_CHECK, REJECT_LIMIT_RST);
		// first record, duplicates, window edges
		send(OP_RECORD, 64'd5000);
		send(OP_CHECK, 64'd5000);
		send(OP_CHECK, 64'd5001);
		send(OP_RECORD, 64'd4999);
		send(OP_RECORD, 64'd4999);
		send(OP_CHECK, 64'd5000 - WIN);
		send(OP_CHECK, 64'd5000 - WIN + 1);
		// far below the highest only marks its slot, which aliases in the window
		send(OP_RECORD, 64'd2000);
		send(OP_CHECK, 64'd2000 + WIN);
		// slide by one less than the window, then by exactly the window
		send(OP_RECORD, 64'd5000 + WIN - 1);
		send(OP_RECORD, 64'd5000 + 2 * WIN - 1);
		send(OP_SPARE, CNT_MAX);
		// top of the range, rejected but still recorded
		send(OP_RECORD, CNT_MAX);
		send(OP_CHECK, CNT_MAX - 5);
		send(OP_CLEAR, 64'd1234);
		send(OP_RECORD, CNT_MAX);
		send(OP_CHECK, '0);
		send(OP_CLEAR, '0);
		send(OP_RECORD, '0);
		send(OP_RECORD, 64'd1);
		cursor = 64'd1;

		// random phases, each with its own limit and sender idling
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       ;
				1:       write_limit(CNT_MAX);
				2:       write_limit('0);
				3:       write_limit(cnt_above(cursor, cnt_t'($urandom_range(0, 3000))));
				4:       write_limit(REJECT_LIMIT_RST);
				default: write_limit(rand64());
			endcase
			case (ph % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 75;
				default: idle_pct = 30;
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pause();
				random_item();
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
